// ===== design/imuf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imuf_pkg: shared types and constants of the IMU tilt filter
// Command and status words between controller and datapath, angle limits,
// register indexes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package imuf_pkg;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_BLEND_GAIN = 2'd0;
    localparam logic [1:0] REG_GYRO_SCALE = 2'd1;
    localparam logic [1:0] REG_TICK_NS    = 2'd2;

    localparam logic [15:0] BLEND_GAIN_RST = 16'd62259;
    localparam logic [7:0]  GYRO_SCALE_RST = 8'd131;
    localparam logic [15:0] TICK_NS_RST    = 16'd1000;

    localparam int ATAN_LEN    = 24;
    localparam int SQRT_STEPS  = 24;
    localparam int DIV_STEPS   = 56;

    localparam logic [22:0] NINETY_Q16 = 23'd5898240;
    localparam logic [15:0] NINETY_Q8  = 16'd23040;
    localparam logic [29:0] NS_PER_S   = 30'd1000000000;

    localparam logic signed [31:0] ANG_MAX = 32'sd262143;
    localparam logic signed [31:0] ANG_MIN = -32'sd262144;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_SQUARE,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_COR_INIT,
        OP_COR_STEP,
        OP_COR_END,
        OP_SEED,
        OP_GYRO_PREP,
        OP_GYRO_MUL,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_GYRO_END,
        OP_BLEND_A,
        OP_BLEND_B,
        OP_BLEND_C,
        OP_PUBLISH
    } imuf_op_t;

    typedef struct packed {
        imuf_op_t   op;
        logic [1:0] axis;
        logic [4:0] iter;
    } imuf_cmd_t;

    typedef struct packed {
        logic first;
    } imuf_status_t;

    // atan(2^-i) in 1/65536 degree, rounded to nearest
    function automatic logic [21:0] atan_q16(input logic [4:0] i);
        logic [21:0] v;
        begin
            case (i)
                5'd0:    v = 22'd2949120;
                5'd1:    v = 22'd1740967;
                5'd2:    v = 22'd919879;
                5'd3:    v = 22'd466945;
                5'd4:    v = 22'd234379;
                5'd5:    v = 22'd117304;
                5'd6:    v = 22'd58666;
                5'd7:    v = 22'd29335;
                5'd8:    v = 22'd14668;
                5'd9:    v = 22'd7334;
                5'd10:   v = 22'd3667;
                5'd11:   v = 22'd1833;
                5'd12:   v = 22'd917;
                5'd13:   v = 22'd458;
                5'd14:   v = 22'd229;
                5'd15:   v = 22'd115;
                5'd16:   v = 22'd57;
                5'd17:   v = 22'd29;
                5'd18:   v = 22'd14;
                5'd19:   v = 22'd7;
                5'd20:   v = 22'd4;
                5'd21:   v = 22'd2;
                5'd22:   v = 22'd1;
                default: v = 22'd0;
            endcase
            return v;
        end
    endfunction

    // clamp to the 19-bit angle range
    function automatic logic signed [18:0] sat19(input logic signed [31:0] v);
        logic signed [18:0] r;
        begin
            if (v > ANG_MAX)
            begin
                r = 19'sh3FFFF;
            end
            else if (v < ANG_MIN)
            begin
                r = 19'sh40000;
            end
            else
            begin
                r = v[18:0];
            end
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== design/imuf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imuf_ctrl: sequencer of the IMU tilt filter
// Walks squares, square roots, CORDIC, gyro division (or the seed on the first
// sample) and blend per axis and drives the datapath by command words.
// ----------------------------------------------------------------------------
module imuf_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire                   out_ready,
    input  imuf_pkg::imuf_status_t status,
    output imuf_pkg::imuf_cmd_t   cmd
);

    localparam int NSTEPS = (CORDIC_STEPS < imuf_pkg::ATAN_LEN) ?
                            CORDIC_STEPS : imuf_pkg::ATAN_LEN;

    typedef enum logic [4:0] {
        S_IDLE, S_SQUARE, S_SQRT_INIT, S_SQRT, S_COR_INIT, S_COR, S_COR_END,
        S_SEED, S_GYRO_PREP, S_GYRO_MUL, S_DIV_INIT, S_DIV, S_GYRO_END,
        S_BLEND_A, S_BLEND_B, S_BLEND_C, S_PUBLISH
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic [5:0] iter_reg, iter_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // next state and command
    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = imuf_pkg::OP_IDLE;
        cmd.axis       = axis_reg;
        cmd.iter       = iter_reg[4:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = imuf_pkg::OP_LOAD;
                    state_next = S_SQUARE;
                    axis_next  = 2'd0;
                end
            end
            S_SQUARE:
            begin
                cmd.op = imuf_pkg::OP_SQUARE;
                if (axis_reg == 2'd2)
                begin
                    axis_next  = 2'd0;
                    state_next = S_SQRT_INIT;
                end
                else
                begin
                    axis_next = axis_reg + 2'd1;
                end
            end
            S_SQRT_INIT:
            begin
                cmd.op     = imuf_pkg::OP_SQRT_INIT;
                iter_next  = 6'd0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op = imuf_pkg::OP_SQRT_STEP;
                if (iter_reg == 6'(imuf_pkg::SQRT_STEPS - 1))
                begin
                    state_next = S_COR_INIT;
                end
                else
                begin
                    iter_next = iter_reg + 6'd1;
                end
            end
            S_COR_INIT:
            begin
                cmd.op     = imuf_pkg::OP_COR_INIT;
                iter_next  = 6'd0;
                state_next = S_COR;
            end
            S_COR:
            begin
                cmd.op = imuf_pkg::OP_COR_STEP;
                if (iter_reg == 6'(NSTEPS - 1))
                begin
                    state_next = S_COR_END;
                end
                else
                begin
                    iter_next = iter_reg + 6'd1;
                end
            end
            S_COR_END:
            begin
                cmd.op = imuf_pkg::OP_COR_END;
                if (axis_reg == 2'd2)
                begin
                    axis_next  = 2'd0;
                    state_next = status.first ? S_SEED : S_GYRO_PREP;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_SQRT_INIT;
                end
            end
            S_SEED:
            begin
                cmd.op     = imuf_pkg::OP_SEED;
                state_next = S_BLEND_A;
            end
            S_GYRO_PREP:
            begin
                cmd.op     = imuf_pkg::OP_GYRO_PREP;
                state_next = S_GYRO_MUL;
            end
            S_GYRO_MUL:
            begin
                cmd.op     = imuf_pkg::OP_GYRO_MUL;
                state_next = S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                cmd.op     = imuf_pkg::OP_DIV_INIT;
                iter_next  = 6'd0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op = imuf_pkg::OP_DIV_STEP;
                if (iter_reg == 6'(imuf_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_GYRO_END;
                end
                else
                begin
                    iter_next = iter_reg + 6'd1;
                end
            end
            S_GYRO_END:
            begin
                cmd.op = imuf_pkg::OP_GYRO_END;
                if (axis_reg == 2'd2)
                begin
                    axis_next  = 2'd0;
                    state_next = S_BLEND_A;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_GYRO_MUL;
                end
            end
            S_BLEND_A:
            begin
                cmd.op     = imuf_pkg::OP_BLEND_A;
                state_next = S_BLEND_B;
            end
            S_BLEND_B:
            begin
                cmd.op     = imuf_pkg::OP_BLEND_B;
                state_next = S_BLEND_C;
            end
            S_BLEND_C:
            begin
                cmd.op = imuf_pkg::OP_BLEND_C;
                if (axis_reg == 2'd2)
                begin
                    axis_next  = 2'd0;
                    state_next = S_PUBLISH;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_BLEND_A;
                end
            end
            S_PUBLISH:
            begin
                if (slot_free)
                begin
                    cmd.op         = imuf_pkg::OP_PUBLISH;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= 2'd0;
            iter_reg      <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/imuf_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imuf_dp: datapath of the IMU tilt filter
// Squares, bit-pair square root, CORDIC vectoring, restoring divider for the
// gyro increment, blend multiply and the result words.
// ----------------------------------------------------------------------------
module imuf_dp (
    input  wire                        clk,
    input  wire                        rst_n,
    input  imuf_pkg::imuf_cmd_t        cmd,
    output imuf_pkg::imuf_status_t     status,
    input  wire signed [15:0]          accel_x,
    input  wire signed [15:0]          accel_y,
    input  wire signed [15:0]          accel_z,
    input  wire signed [15:0]          rate_x,
    input  wire signed [15:0]          rate_y,
    input  wire signed [15:0]          rate_z,
    input  wire [15:0]                 elapsed_ticks,
    input  wire [15:0]                 blend_gain,
    input  wire [7:0]                  gyro_counts_per_dps,
    input  wire [15:0]                 tick_length_ns,
    output logic signed [18:0]         tilt_x,
    output logic signed [18:0]         tilt_y,
    output logic signed [18:0]         tilt_z
);

    function automatic logic [16:0] mag16(input logic signed [15:0] v);
        logic signed [16:0] e;
        begin
            e = {v[15], v};
            return v[15] ? 17'(-e) : 17'(e);
        end
    endfunction

    // sample and state registers
    logic signed [15:0] accel_reg [3];
    logic signed [15:0] rate_reg [3];
    logic [15:0]        ticks_reg;
    logic [30:0]        sq_reg [3];
    logic signed [18:0] acc_reg [3];
    logic signed [18:0] integ_reg [3];
    logic signed [18:0] res_reg [3];
    logic               first_reg;

    logic [47:0]        rad_reg;
    logic [26:0]        srem_reg;
    logic [23:0]        root_reg;

    logic signed [27:0] cx_reg, cy_reg;
    logic signed [24:0] cz_reg;
    logic               num_zero_reg, den_zero_reg;

    logic [31:0]        tl_reg;
    logic [37:0]        den_reg;
    logic [47:0]        prod_reg;
    logic [55:0]        dvd_reg;
    logic [38:0]        drem_reg;
    logic [26:0]        quo_reg;
    logic signed [36:0] pa_reg, pb_reg;
    logic signed [18:0] tilt_x_reg, tilt_y_reg, tilt_z_reg;

    // per-axis selects
    logic signed [15:0] a_sel, r_sel;
    logic signed [18:0] acc_sel, integ_sel;
    logic [31:0]        pair_sum;
    logic [16:0]        a_mag, az_mag, r_mag;

    always_comb
    begin
        case (cmd.axis)
            2'd0:
            begin
                a_sel     = accel_reg[0];
                r_sel     = rate_reg[0];
                acc_sel   = acc_reg[0];
                integ_sel = integ_reg[0];
                pair_sum  = {1'b0, sq_reg[1]} + {1'b0, sq_reg[2]};
            end
            2'd1:
            begin
                a_sel     = accel_reg[1];
                r_sel     = rate_reg[1];
                acc_sel   = acc_reg[1];
                integ_sel = integ_reg[1];
                pair_sum  = {1'b0, sq_reg[0]} + {1'b0, sq_reg[2]};
            end
            default:
            begin
                a_sel     = accel_reg[2];
                r_sel     = rate_reg[2];
                acc_sel   = acc_reg[2];
                integ_sel = integ_reg[2];
                pair_sum  = {1'b0, sq_reg[0]} + {1'b0, sq_reg[1]};
            end
        endcase
    end

    assign a_mag  = mag16(a_sel);
    assign az_mag = mag16(accel_reg[2]);
    assign r_mag  = mag16(r_sel);

    // square
    logic signed [31:0] sq_full;
    assign sq_full = a_sel * a_sel;

    // square root step: two radicand bits a cycle
    logic [26:0] s_part, s_trial;
    assign s_part  = {srem_reg[24:0], rad_reg[47:46]};
    assign s_trial = {1'b0, root_reg, 2'b01};

    // CORDIC operands and step
    logic [24:0]        c_num, c_den;
    logic signed [27:0] c_dx, c_dy;
    logic signed [24:0] c_at;
    always_comb
    begin
        if (cmd.axis == 2'd2)
        begin
            c_num = {1'b0, root_reg};
            c_den = {az_mag, 8'd0};
        end
        else
        begin
            c_num = {a_mag, 8'd0};
            c_den = {1'b0, root_reg};
        end
    end
    assign c_dx = cy_reg >>> cmd.iter;
    assign c_dy = cx_reg >>> cmd.iter;
    assign c_at = $signed({3'b000, imuf_pkg::atan_q16(cmd.iter)});

    // CORDIC finish: clamp, round, sign
    logic [22:0]        z_clamp;
    logic [23:0]        z_round;
    logic [15:0]        ang_mag;
    logic signed [18:0] ang_signed;
    always_comb
    begin
        if (cz_reg < 0)
        begin
            z_clamp = 23'd0;
        end
        else if (cz_reg > $signed({2'b00, imuf_pkg::NINETY_Q16}))
        begin
            z_clamp = imuf_pkg::NINETY_Q16;
        end
        else
        begin
            z_clamp = cz_reg[22:0];
        end
        z_round = {1'b0, z_clamp} + 24'd128;
        priority if (num_zero_reg)
        begin
            ang_mag = 16'd0;
        end
        else if (den_zero_reg)
        begin
            ang_mag = imuf_pkg::NINETY_Q8;
        end
        else
        begin
            ang_mag = z_round[23:8];
        end
        ang_signed = a_sel[15] ? -$signed({3'b000, ang_mag}) : $signed({3'b000, ang_mag});
    end

    // gyro increment
    logic [7:0]         scale_eff;
    logic [38:0]        d_part;
    logic signed [27:0] inc;
    logic signed [28:0] integ_sum;
    assign scale_eff = (gyro_counts_per_dps == 8'd0) ? 8'd1 : gyro_counts_per_dps;
    assign d_part    = {drem_reg[37:0], dvd_reg[55]};
    assign inc       = r_sel[15] ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign integ_sum = 29'(integ_sel) + 29'(inc);

    // blend
    logic signed [17:0] w_acc, w_int;
    logic signed [37:0] b_sum;
    assign w_acc = $signed(18'd65536 - {2'b00, blend_gain});
    assign w_int = $signed({2'b00, blend_gain});
    assign b_sum = 38'(pa_reg) + 38'(pb_reg) + 38'sd32768;

    // first-sample flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
        end
        else if (cmd.op == imuf_pkg::OP_SEED)
        begin
            first_reg <= 1'b0;
        end
    end
    assign status.first = first_reg;

    // integrated angles
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg[0] <= '0;
            integ_reg[1] <= '0;
            integ_reg[2] <= '0;
        end
        else if (cmd.op == imuf_pkg::OP_SEED)
        begin
            integ_reg[0] <= acc_reg[0];
            integ_reg[1] <= acc_reg[1];
            integ_reg[2] <= acc_reg[2];
        end
        else if (cmd.op == imuf_pkg::OP_GYRO_END)
        begin
            integ_reg[cmd.axis] <= imuf_pkg::sat19(32'(integ_sum));
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            imuf_pkg::OP_LOAD:
            begin
                accel_reg[0] <= accel_x;
                accel_reg[1] <= accel_y;
                accel_reg[2] <= accel_z;
                rate_reg[0]  <= rate_x;
                rate_reg[1]  <= rate_y;
                rate_reg[2]  <= rate_z;
                ticks_reg    <= elapsed_ticks;
            end
            imuf_pkg::OP_SQUARE:
            begin
                sq_reg[cmd.axis] <= sq_full[30:0];
            end
            imuf_pkg::OP_SQRT_INIT:
            begin
                rad_reg  <= {pair_sum, 16'd0};
                srem_reg <= '0;
                root_reg <= '0;
            end
            imuf_pkg::OP_SQRT_STEP:
            begin
                rad_reg <= {rad_reg[45:0], 2'b00};
                if (s_part >= s_trial)
                begin
                    srem_reg <= s_part - s_trial;
                    root_reg <= {root_reg[22:0], 1'b1};
                end
                else
                begin
                    srem_reg <= s_part;
                    root_reg <= {root_reg[22:0], 1'b0};
                end
            end
            imuf_pkg::OP_COR_INIT:
            begin
                cx_reg       <= $signed({3'b000, c_den});
                cy_reg       <= $signed({3'b000, c_num});
                cz_reg       <= '0;
                num_zero_reg <= (c_num == 25'd0);
                den_zero_reg <= (c_den == 25'd0);
            end
            imuf_pkg::OP_COR_STEP:
            begin
                if (cy_reg >= 0)
                begin
                    cx_reg <= cx_reg + c_dx;
                    cy_reg <= cy_reg - c_dy;
                    cz_reg <= cz_reg + c_at;
                end
                else
                begin
                    cx_reg <= cx_reg - c_dx;
                    cy_reg <= cy_reg + c_dy;
                    cz_reg <= cz_reg - c_at;
                end
            end
            imuf_pkg::OP_COR_END:
            begin
                acc_reg[cmd.axis] <= ang_signed;
            end
            imuf_pkg::OP_GYRO_PREP:
            begin
                tl_reg  <= ticks_reg * tick_length_ns;
                den_reg <= 38'(scale_eff) * 38'(imuf_pkg::NS_PER_S);
            end
            imuf_pkg::OP_GYRO_MUL:
            begin
                prod_reg <= tl_reg * r_mag;
            end
            imuf_pkg::OP_DIV_INIT:
            begin
                dvd_reg  <= {prod_reg, 8'd0} + {19'd0, den_reg[37:1]};
                drem_reg <= '0;
                quo_reg  <= '0;
            end
            imuf_pkg::OP_DIV_STEP:
            begin
                dvd_reg <= {dvd_reg[54:0], 1'b0};
                if (d_part >= {1'b0, den_reg})
                begin
                    drem_reg <= d_part - {1'b0, den_reg};
                    quo_reg  <= {quo_reg[25:0], 1'b1};
                end
                else
                begin
                    drem_reg <= d_part;
                    quo_reg  <= {quo_reg[25:0], 1'b0};
                end
            end
            imuf_pkg::OP_BLEND_A:
            begin
                pa_reg <= acc_sel * w_acc;
            end
            imuf_pkg::OP_BLEND_B:
            begin
                pb_reg <= integ_sel * w_int;
            end
            imuf_pkg::OP_BLEND_C:
            begin
                // arithmetic shift by 16 keeps the sign
                res_reg[cmd.axis] <= imuf_pkg::sat19(32'($signed(b_sum[37:16])));
            end
            imuf_pkg::OP_PUBLISH:
            begin
                tilt_x_reg <= res_reg[0];
                tilt_y_reg <= res_reg[1];
                tilt_z_reg <= res_reg[2];
            end
            default:
            begin
            end
        endcase
    end

    assign tilt_x = tilt_x_reg;
    assign tilt_y = tilt_y_reg;
    assign tilt_z = tilt_z_reg;

endmodule
`default_nettype wire

// ===== design/imu_complementary_tilt_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter: accelerometer tilt blended with gyro angle
// Channel   Signals                          Word
// in        in_valid / in_ready              accel_x..z, rate_x..z, ticks
// out       out_valid / out_ready            tilt_x, tilt_y, tilt_z
// cfg       psel penable pwrite paddr pwdata blend gain, gyro scale, tick ns
//
// One word at a time, paced by the one-bit-a-cycle divider, the two-bit-a-cycle
// square root and min(CORDIC_STEPS, 24) CORDIC steps per axis.
// Reset raises the first-sample flag and clears the integrated angles at once.
// A finished word waits in the output register; the next word is taken
// while it waits, and the sequencer holds before publishing if still full.
// ----------------------------------------------------------------------------
module imu_complementary_tilt_filter #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire signed [15:0]  accel_x,
    input  wire signed [15:0]  accel_y,
    input  wire signed [15:0]  accel_z,
    input  wire signed [15:0]  rate_x,
    input  wire signed [15:0]  rate_y,
    input  wire signed [15:0]  rate_z,
    input  wire [15:0]         elapsed_ticks,
    output logic               out_valid,
    input  wire                out_ready,
    output logic signed [18:0] tilt_x,
    output logic signed [18:0] tilt_y,
    output logic signed [18:0] tilt_z,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire [3:0]          paddr,
    input  wire [31:0]         pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [15:0] blend_gain_reg;
    logic [7:0]  gyro_scale_reg;
    logic [15:0] tick_ns_reg;
    logic        cfg_write;

    imuf_pkg::imuf_cmd_t    cmd;
    imuf_pkg::imuf_status_t status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_gain_reg <= imuf_pkg::BLEND_GAIN_RST;
            gyro_scale_reg <= imuf_pkg::GYRO_SCALE_RST;
            tick_ns_reg    <= imuf_pkg::TICK_NS_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                imuf_pkg::REG_BLEND_GAIN: blend_gain_reg <= pwdata[15:0];
                imuf_pkg::REG_GYRO_SCALE: gyro_scale_reg <= pwdata[7:0];
                imuf_pkg::REG_TICK_NS:    tick_ns_reg    <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // register read-back
    always_comb
    begin
        case (paddr[3:2])
            imuf_pkg::REG_BLEND_GAIN: prdata = {16'd0, blend_gain_reg};
            imuf_pkg::REG_GYRO_SCALE: prdata = {24'd0, gyro_scale_reg};
            imuf_pkg::REG_TICK_NS:    prdata = {16'd0, tick_ns_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    imuf_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    imuf_dp u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .accel_x             (accel_x),
        .accel_y             (accel_y),
        .accel_z             (accel_z),
        .rate_x              (rate_x),
        .rate_y              (rate_y),
        .rate_z              (rate_z),
        .elapsed_ticks       (elapsed_ticks),
        .blend_gain          (blend_gain_reg),
        .gyro_counts_per_dps (gyro_scale_reg),
        .tick_length_ns      (tick_ns_reg),
        .tilt_x              (tilt_x),
        .tilt_y              (tilt_y),
        .tilt_z              (tilt_z)
    );

endmodule
`default_nettype wire

// ===== tb/sv/imu_complementary_tilt_filter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter_test: self-checking bench of the tilt filter
// Drives IMU sample words through the valid/ready input, and accepts tilt words
// with random stalls on both sides. Each tilt word is checked against a local
// fixed-point filter model. The APB registers are written and read back
// between phases, over extreme and random settings.
// ----------------------------------------------------------------------------
module imu_complementary_tilt_filter_test;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 400;
    localparam int RAND_PHASES    = 10;
    localparam int RAND_PER_PHASE = 50;

    typedef struct {
        logic signed [15:0] ax, ay, az, gx, gy, gz;
        logic [15:0]        ticks;
        bit                 known;
        logic signed [18:0] ex, ey, ez;
    } sample_row_t;

    typedef struct {
        logic signed [18:0] tx, ty, tz;
    } tilt_word_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] accel_x, accel_y, accel_z;
    logic signed [15:0] rate_x, rate_y, rate_z;
    logic [15:0]        elapsed_ticks;
    logic               out_valid;
    logic               out_ready;
    logic signed [18:0] tilt_x, tilt_y, tilt_z;
    logic               psel, penable, pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // filter model state and register copies
    bit          seed_pending;
    longint      integ_angle [3];
    longint      gain_q16;
    longint      gyro_scale;
    longint      tick_ns;
    longint      atan_tab [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    tilt_word_t  tilt_expected [$];
    sample_row_t directed_rows [$];
    int          errors;
    int          reported;
    int          words_in;
    int          words_out;
    int          idle_cycles;
    bit          burst_mode;

    imu_complementary_tilt_filter #(.CORDIC_STEPS(16)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
        .rate_x(rate_x), .rate_y(rate_y), .rate_z(rate_z),
        .elapsed_ticks(elapsed_ticks),
        .out_valid(out_valid), .out_ready(out_ready),
        .tilt_x(tilt_x), .tilt_y(tilt_y), .tilt_z(tilt_z),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // integer square root, two bits per pass
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        begin
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (v >= res + bitv)
                begin
                    v   = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        end
    endfunction

    // hypotenuse in Q8
    function automatic longint hypot_q8(input longint p, input longint q);
        longint unsigned s;
        begin
            s = longint'(p * p) + longint'(q * q);
            return longint'(int_sqrt(s << 16));
        end
    endfunction

    // vectoring CORDIC arctangent, 1/256 degree
    function automatic longint tilt_angle(input longint num, input longint den,
                                          input bit neg);
        longint x, y, z, dx, dy, r;
        begin
            if (num == 0)
            begin
                return 0;
            end
            if (den == 0)
            begin
                r = 90 * 256;
            end
            else
            begin
                x = den;
                y = num;
                z = 0;
                for (int i = 0; i < 16; i++)
                begin
                    dx = y >>> i;
                    dy = x >>> i;
                    if (y >= 0)
                    begin
                        x = x + dx;
                        y = y - dy;
                        z = z + atan_tab[i];
                    end
                    else
                    begin
                        x = x - dx;
                        y = y + dy;
                        z = z - atan_tab[i];
                    end
                end
                if (z < 0) z = 0;
                if (z > 90 * 65536) z = 90 * 65536;
                r = (z + 128) >>> 8;
            end
            return neg ? -r : r;
        end
    endfunction

    function automatic longint clamp19(input longint v);
        begin
            if (v > 262143) return 262143;
            if (v < -262144) return -262144;
            return v;
        end
    endfunction

    function automatic longint mag(input longint v);
        return v < 0 ? -v : v;
    endfunction

    // advance the filter model by one sample, return the tilt word
    function automatic tilt_word_t filter_sample(input sample_row_t s);
        longint acc [3];
        longint rate [3];
        longint unsigned num, den, scl;
        longint inc, sum;
        longint tilt [3];
        tilt_word_t w;
        begin
            rate[0] = s.gx;
            rate[1] = s.gy;
            rate[2] = s.gz;
            acc[0] = tilt_angle(mag(s.ax) * 256, hypot_q8(s.ay, s.az), s.ax < 0);
            acc[1] = tilt_angle(mag(s.ay) * 256, hypot_q8(s.ax, s.az), s.ay < 0);
            acc[2] = tilt_angle(hypot_q8(s.ax, s.ay), mag(s.az) * 256, s.az < 0);
            if (seed_pending)
            begin
                seed_pending = 1'b0;
                for (int k = 0; k < 3; k++) integ_angle[k] = acc[k];
            end
            else
            begin
                scl = (gyro_scale == 0) ? 1 : gyro_scale;
                den = scl * 64'd1000000000;
                for (int k = 0; k < 3; k++)
                begin
                    num = longint'(s.ticks) * tick_ns * mag(rate[k]) * 256;
                    inc = longint'((num + den / 2) / den);
                    if (rate[k] < 0) inc = -inc;
                    integ_angle[k] = clamp19(integ_angle[k] + inc);
                end
            end
            for (int k = 0; k < 3; k++)
            begin
                sum = acc[k] * (65536 - gain_q16) + integ_angle[k] * gain_q16;
                tilt[k] = clamp19((sum + 32768) >>> 16);
            end
            w.tx = tilt[0][18:0];
            w.ty = tilt[1][18:0];
            w.tz = tilt[2][18:0];
            return w;
        end
    endfunction

    function automatic sample_row_t mk_row(input int ax, ay, az, gx, gy, gz, tk,
                                           input bit known = 0,
                                           input int ex = 0, ey = 0, ez = 0);
        sample_row_t r;
        begin
            r.ax = 16'(ax); r.ay = 16'(ay); r.az = 16'(az);
            r.gx = 16'(gx); r.gy = 16'(gy); r.gz = 16'(gz);
            r.ticks = 16'(tk);
            r.known = known;
            r.ex = 19'(ex); r.ey = 19'(ey); r.ez = 19'(ez);
            return r;
        end
    endfunction

    // raw 16-bit value with extra weight on zero, extremes and small values
    function automatic logic [15:0] raw_value();
        int pick;
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: return 16'h0000;
                1: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
                2, 3, 4:
                    return ($urandom_range(0, 1) != 0)
                        ? 16'($urandom_range(0, 300)) : -16'($urandom_range(0, 300));
                default: return 16'($urandom);
            endcase
        end
    endfunction

    function automatic sample_row_t random_row();
        sample_row_t r;
        int pick;
        begin
            r = mk_row(0, 0, 0, 0, 0, 0, 0);
            r.ax = raw_value(); r.ay = raw_value(); r.az = raw_value();
            r.gx = raw_value(); r.gy = raw_value(); r.gz = raw_value();
            pick = $urandom_range(0, 9);
            if (pick == 0)
                r.ticks = '0;
            else if (pick < 4)
                r.ticks = 16'($urandom);
            else
                r.ticks = 16'($urandom_range(1, 2000));
            return r;
        end
    endfunction

    // present one word and hold it until the filter takes it
    task automatic send_sample(input sample_row_t s);
        int gap;
        tilt_word_t w;
        begin
            gap = burst_mode ? 0 : $urandom_range(0, 15);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            accel_x <= s.ax; accel_y <= s.ay; accel_z <= s.az;
            rate_x <= s.gx; rate_y <= s.gy; rate_z <= s.gz;
            elapsed_ticks <= s.ticks;
            in_valid <= 1'b1;
            do @(posedge clk); while (!(in_valid && in_ready));
            w = filter_sample(s);
            if (s.known && (w.tx !== s.ex || w.ty !== s.ey || w.tz !== s.ez))
            begin
                $display("model disagrees with table row: %0d %0d %0d", w.tx, w.ty, w.tz);
                errors++;
            end
            if (s.known)
            begin
                w.tx = s.ex; w.ty = s.ey; w.tz = s.ez;
            end
            tilt_expected.push_back(w);
            words_in++;
        end
    endtask

    task automatic drain_and_settle();
        begin
            in_valid <= 1'b0;
            while (tilt_expected.size() != 0) @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    // APB write then read back
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value,
                             input logic [31:0] width_mask);
        begin
            psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
            paddr <= {idx, 2'b00}; pwdata <= value;
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0;
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            if ((prdata & width_mask) !== (value & width_mask))
            begin
                $display("register %0d read back %h, wrote %h", idx, prdata, value);
                errors++;
            end
            psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic set_config(input int g, input int sc, input int tk);
        begin
            reg_write(imuf_pkg::REG_BLEND_GAIN, g, 32'hFFFF);
            reg_write(imuf_pkg::REG_GYRO_SCALE, sc, 32'hFF);
            reg_write(imuf_pkg::REG_TICK_NS, tk, 32'hFFFF);
            gain_q16   = g & 16'hFFFF;
            gyro_scale = sc & 8'hFF;
            tick_ns    = tk & 16'hFFFF;
        end
    endtask

    // output side: random stalls, compare against oldest expectation
    initial
    begin
        int stall;
        tilt_word_t w;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = burst_mode ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            words_out++;
            if (tilt_expected.size() == 0)
            begin
                errors++;
                if (reported < 10)
                begin
                    $display("unexpected tilt word %0d %0d %0d", tilt_x, tilt_y, tilt_z);
                    reported++;
                end
            end
            else
            begin
                w = tilt_expected.pop_front();
                if (tilt_x !== w.tx || tilt_y !== w.ty || tilt_z !== w.tz)
                begin
                    errors++;
                    if (reported < 10)
                    begin
                        $display("word %0d: expected %0d %0d %0d, got %0d %0d %0d",
                                 words_out, w.tx, w.ty, w.tz, tilt_x, tilt_y, tilt_z);
                        reported++;
                    end
                end
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("imu_complementary_tilt_filter_test: FAIL");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        int g, sc, tk;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        accel_x <= '0; accel_y <= '0; accel_z <= '0;
        rate_x <= '0; rate_y <= '0; rate_z <= '0;
        elapsed_ticks <= '0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        paddr <= '0; pwdata <= '0;
        errors = 0; reported = 0; words_in = 0; words_out = 0;
        idle_cycles = 0; burst_mode = 1'b0;
        seed_pending = 1'b1;
        for (int k = 0; k < 3; k++) integ_angle[k] = 0;
        gain_q16 = imuf_pkg::BLEND_GAIN_RST;
        gyro_scale = imuf_pkg::GYRO_SCALE_RST;
        tick_ns = imuf_pkg::TICK_NS_RST;

        // first row seeds from the accel angles, so output equals them
        directed_rows.push_back(mk_row(16384, 0, 0, 0, 0, 0, 0, 1, 23040, 0, 23040));
        directed_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(0, 0, -1000, 0, 0, 0, 100));
        directed_rows.push_back(mk_row(-32768, -32768, -32768, -32768, -32768,
                                       -32768, 65535));
        directed_rows.push_back(mk_row(32767, 32767, 32767, 32767, 32767, 32767, 65535));
        directed_rows.push_back(mk_row(0, 5000, 0, 0, 0, 0, 10));
        directed_rows.push_back(mk_row(0, 0, 0, 32767, -32768, 1, 0));
        directed_rows.push_back(mk_row(-32768, 0, 0, 0, 0, 0, 1));
        directed_rows.push_back(mk_row(1, 1, 1, 1, 1, 1, 1));
        directed_rows.push_back(mk_row(100, -200, 16384, 131, -131, 0, 1000));
        directed_rows.push_back(mk_row(0, -1, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(-5, 0, 3, -1, 1, -32768, 1));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) send_sample(directed_rows[i]);
        drain_and_settle();

        // extreme settings, then random ones, each with a batch of samples
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0: begin g = 0;     sc = 1;   tk = 65535; end
                1: begin g = 65535; sc = 255; tk = 1;     end
                2: begin g = 32768; sc = 0;   tk = 0;     end
                3: begin g = 65535; sc = 1;   tk = 65535; end
                4: begin g = 62259; sc = 131; tk = 1000;  end
                default:
                begin
                    g  = $urandom_range(0, 65535);
                    sc = $urandom_range(1, 255);
                    tk = $urandom_range(1, 65535);
                end
            endcase
            set_config(g, sc, tk);
            burst_mode = (ph % 4 == 3);
            for (int n = 0; n < RAND_PER_PHASE; n++) send_sample(random_row());
            drain_and_settle();
        end

        $display("ran %0d sample words, %0d tilt words over %0d register settings",
                 words_in, words_out, RAND_PHASES + 1);
        $display("mismatches: %0d", errors);
        if (errors == 0)
            $display("imu_complementary_tilt_filter_test: PASS");
        else
            $display("imu_complementary_tilt_filter_test: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
design/imuf_pkg.sv
design/imuf_ctrl.sv
design/imuf_dp.sv
design/imu_complementary_tilt_filter.sv
tb/sv/imu_complementary_tilt_filter_test.sv
